// ----- rtl/ufr_pkg.sv -----
`default_nettype none

package ufr_pkg;

    // Frame checks.
    localparam logic [15:0] MIN_FRAME_LEN = 16'd114;
    localparam logic [7:0]  CMD_CODE      = 8'h11;
    localparam logic [7:0]  SUB_CODE      = 8'h2A;
    localparam logic [7:0]  RTN_OK        = 8'h00;
    localparam logic [16:0] SUM_MODULUS   = 17'h10000;
    localparam logic [15:0] COUNT_MAX     = 16'hFFFF;

    // Layout of a frame, the start character being byte 0.
    localparam logic [15:0] VALUE_BASE    = 16'd15;
    localparam logic [15:0] HEADER_FIRST  = 16'd1;
    localparam logic [15:0] HEADER_LAST   = 16'd8;
    localparam logic [15:0] SUM_FIRST     = 16'd5;
    localparam int          CHARS_PER_VAL = 8;

    localparam int VALUE_INDEX_W = 4;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_SHORT = 3'd1,
        ST_CSUM  = 3'd2,
        ST_CMD   = 3'd3,
        ST_ADDR  = 3'd4,
        ST_SUB   = 3'd5,
        ST_RTN   = 3'd6
    } t_status;

    typedef enum logic [2:0] {
        CFG_START_CHAR = 3'd0,
        CFG_END_CHAR   = 3'd1,
        CFG_IDS_A      = 3'd2,
        CFG_IDS_B      = 3'd3,
        CFG_IDS_C      = 3'd4,
        CFG_IDS_D      = 3'd5
    } t_cfg_index;

    // Verdict of a closed frame, handed from the parser to the result buffer.
    typedef struct packed {
        t_status    status;
        logic [7:0] addr;
        logic       bank;
    } t_job;

    // Non-hex characters decode as zero; both letter cases are accepted.
    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [3:0] n;
        n = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            n = c[3:0];
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            n = c[3:0] + 4'd9;
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/ufr_byte_if.sv -----
`default_nettype none

interface ufr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

// ----- rtl/ufr_res_if.sv -----
`default_nettype none

interface ufr_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [7:0]  device_address;
    logic [3:0]  value_index;
    logic [31:0] value_word;
    logic        last;

    modport source (output valid, output status, output device_address,
                    output value_index, output value_word, output last,
                    input ready);
    modport sink   (input valid, input status, input device_address,
                    input value_index, input value_word, input last,
                    output ready);
endinterface

`default_nettype wire

// ----- rtl/ups_ascii_frame_receiver_top.sv -----
// A result transaction leaves through the job register, the read stage and the output
// register after the end character is accepted; an accepted frame then streams VALUE_COUNT
// transactions, one a cycle when the sink is ready. Throughput: one byte a cycle; the end
// character of a frame waits only while the verdict of the previous frame is still reading
// its words out of the value memory. Reset is synchronous and active low; it restores the
// default configuration and leaves the receiver outside a frame with no result pending.
`default_nettype none

module ups_ascii_frame_receiver_top #(
    parameter int VALUE_COUNT = 11
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data,
    ufr_byte_if.sink         i_byte,
    ufr_res_if.source        o_res
);

    localparam int IDX_W = (VALUE_COUNT > 1) ? $clog2(VALUE_COUNT) : 1;

    // Configuration registers. The four bitmaps together cover all 256 addresses.
    logic [7:0]       r_start_char;
    logic [7:0]       r_end_char;
    logic [3:0][63:0] r_ids;

    // Per-frame state. The running sum lags the input by four bytes, so the
    // checksum characters sitting in the tail window are never summed.
    logic        r_in_frame;
    logic [15:0] r_byte_count;
    logic [15:0] r_sum;
    logic [3:0][7:0] r_tail;
    logic [31:0] r_header;
    logic [31:0] r_acc;
    logic        r_wr_bank;

    logic        w_acc;
    logic [7:0]  w_b;
    logic        w_is_start;
    logic        w_is_end;
    logic        w_close_byte;
    logic        w_close;
    logic        w_open;
    logic        w_data;
    logic        w_job_busy;
    logic [3:0]  w_nib;
    logic [15:0] w_pos_off;
    logic        w_in_values;
    logic        w_wr_en;
    logic [31:0] w_wr_data;
    logic [15:0] w_got;
    logic [15:0] w_expect;
    logic [7:0]  w_cmd;
    logic [7:0]  w_addr;
    logic [7:0]  w_sub;
    logic [7:0]  w_rtn;
    logic        w_id_ok;
    ufr_pkg::t_status w_status;
    ufr_pkg::t_job    w_job;

    assign w_b        = i_byte.in_byte;
    assign w_is_start = (w_b == r_start_char);
    assign w_is_end   = (w_b == r_end_char);

    // The end character of a frame is held off while the previous verdict is
    // still being issued; every other byte goes straight in.
    assign w_close_byte  = r_in_frame && w_is_end;
    assign i_byte.ready  = !(w_close_byte && w_job_busy);
    assign w_acc         = i_byte.valid && i_byte.ready;

    // A byte equal to both delimiters closes an open frame rather than restarting it.
    assign w_close = w_acc && w_close_byte;
    assign w_open  = w_acc && w_is_start && !w_close_byte;
    assign w_data  = w_acc && r_in_frame && !w_is_end && !w_is_start;

    assign w_nib = ufr_pkg::hex_nibble(w_b);

    // Value k occupies eight characters starting at VALUE_BASE + 8k. Characters are
    // shifted into an accumulator and the word is written to memory on its last one.
    assign w_pos_off   = r_byte_count - ufr_pkg::VALUE_BASE;
    assign w_in_values = (r_byte_count >= ufr_pkg::VALUE_BASE)
                      && (w_pos_off < 16'(ufr_pkg::CHARS_PER_VAL * VALUE_COUNT));
    assign w_wr_data   = {r_acc[27:0], w_nib};
    assign w_wr_en     = w_data && w_in_values && (w_pos_off[2:0] == 3'd7);

    // Frame verdict, evaluated on the end character.
    assign w_got    = {ufr_pkg::hex_nibble(r_tail[0]), ufr_pkg::hex_nibble(r_tail[1]),
                       ufr_pkg::hex_nibble(r_tail[2]), ufr_pkg::hex_nibble(r_tail[3])};
    assign w_expect = 16'(ufr_pkg::SUM_MODULUS - {1'b0, r_sum});
    assign w_cmd    = r_header[31:24];
    assign w_addr   = r_header[23:16];
    assign w_sub    = r_header[15:8];
    assign w_rtn    = r_header[7:0];
    assign w_id_ok  = r_ids[w_addr[7:6]][w_addr[5:0]];

    // The checks are taken in priority order; the first one to fail names the status.
    always_comb begin
        if (r_byte_count < ufr_pkg::MIN_FRAME_LEN - 16'd1) begin
            w_status = ufr_pkg::ST_SHORT;
        end else if (w_expect != w_got) begin
            w_status = ufr_pkg::ST_CSUM;
        end else if (w_cmd != ufr_pkg::CMD_CODE) begin
            w_status = ufr_pkg::ST_CMD;
        end else if (!w_id_ok) begin
            w_status = ufr_pkg::ST_ADDR;
        end else if (w_sub != ufr_pkg::SUB_CODE) begin
            w_status = ufr_pkg::ST_SUB;
        end else if (w_rtn != ufr_pkg::RTN_OK) begin
            w_status = ufr_pkg::ST_RTN;
        end else begin
            w_status = ufr_pkg::ST_OK;
        end
    end

    always_comb begin
        w_job.status = w_status;
        w_job.addr   = (w_status == ufr_pkg::ST_SHORT) ? 8'd0 : w_addr;
        w_job.bank   = r_wr_bank;
    end

    // Configuration writes; indexes beyond the register list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_char <= 8'h7E;
            r_end_char   <= 8'h0D;
            r_ids        <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ufr_pkg::CFG_START_CHAR: r_start_char <= i_cfg_data[7:0];
                ufr_pkg::CFG_END_CHAR:   r_end_char   <= i_cfg_data[7:0];
                ufr_pkg::CFG_IDS_A:      r_ids[0]     <= i_cfg_data;
                ufr_pkg::CFG_IDS_B:      r_ids[1]     <= i_cfg_data;
                ufr_pkg::CFG_IDS_C:      r_ids[2]     <= i_cfg_data;
                ufr_pkg::CFG_IDS_D:      r_ids[3]     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Frame tracking. An accepted frame hands its memory bank to the reader and
    // the next frame fills the other bank.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame   <= 1'b0;
            r_byte_count <= '0;
            r_sum        <= '0;
            r_tail       <= '0;
            r_header     <= '0;
            r_wr_bank    <= 1'b0;
        end else if (w_open) begin
            r_in_frame   <= 1'b1;
            r_byte_count <= 16'd1;
            r_sum        <= '0;
            r_tail       <= '0;
            r_header     <= '0;
        end else if (w_close) begin
            r_in_frame <= 1'b0;
            if (w_status == ufr_pkg::ST_OK) begin
                r_wr_bank <= !r_wr_bank;
            end
        end else if (w_data) begin
            if (r_byte_count >= ufr_pkg::SUM_FIRST) begin
                r_sum <= r_sum + {8'd0, r_tail[0]};
            end
            r_tail <= {w_b, r_tail[3], r_tail[2], r_tail[1]};
            if (r_byte_count >= ufr_pkg::HEADER_FIRST && r_byte_count <= ufr_pkg::HEADER_LAST) begin
                r_header <= {r_header[27:0], w_nib};
            end
            if (r_byte_count != ufr_pkg::COUNT_MAX) begin
                r_byte_count <= r_byte_count + 16'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_data) begin
            r_acc <= w_wr_data;
        end
    end

    ufr_value_buf #(
        .VALUE_COUNT (VALUE_COUNT)
    ) u_value_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_en     (w_wr_en),
        .i_wr_addr   ({r_wr_bank, w_pos_off[IDX_W+2:3]}),
        .i_wr_data   (w_wr_data),
        .i_job_valid (w_close),
        .i_job       (w_job),
        .o_job_busy  (w_job_busy),
        .o_res       (o_res)
    );

`ifndef SYNTH
    a_count_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_frame |-> (r_byte_count != 16'd0))
        else $error("open frame with zero byte count");

    a_close_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_close |-> !w_job_busy)
        else $error("frame closed while previous verdict still busy");

    a_open_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_open |=> (r_in_frame && r_byte_count == 16'd1))
        else $error("start character did not open a frame");
`endif

endmodule

`default_nettype wire

// ----- rtl/ufr_value_buf.sv -----
`default_nettype none

module ufr_value_buf #(
    parameter int  VALUE_COUNT = 11,
    localparam int IDX_W       = (VALUE_COUNT > 1) ? $clog2(VALUE_COUNT) : 1
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_wr_en,
    input  wire logic [IDX_W:0]  i_wr_addr,
    input  wire logic [31:0]     i_wr_data,
    input  wire logic            i_job_valid,
    input  wire ufr_pkg::t_job   i_job,
    output logic                 o_job_busy,
    ufr_res_if.source            o_res
);

    localparam int DEPTH = 2 << IDX_W;

    // Two banks of decoded words: one being filled, one being read out.
    logic [31:0] r_mem [0:DEPTH-1];
    logic [31:0] r_rd_data;

    logic             r_job_valid;
    ufr_pkg::t_job    r_job;
    logic [IDX_W-1:0] r_idx;

    logic             r_s1_valid;
    ufr_pkg::t_status r_s1_status;
    logic [7:0]       r_s1_addr;
    logic [IDX_W-1:0] r_s1_idx;
    logic             r_s1_last;

    logic             r_out_valid;
    ufr_pkg::t_status r_out_status;
    logic [7:0]       r_out_addr;
    logic [IDX_W-1:0] r_out_idx;
    logic [31:0]      r_out_word;
    logic             r_out_last;

    logic w_job_ok;
    logic w_last_issue;
    logic w_out_free;
    logic w_s1_adv;
    logic w_issue;

    assign w_job_ok     = (r_job.status == ufr_pkg::ST_OK);
    assign w_last_issue = !w_job_ok || (r_idx == IDX_W'(VALUE_COUNT - 1));
    assign w_out_free   = !r_out_valid || o_res.ready;
    assign w_s1_adv     = r_s1_valid && w_out_free;
    assign w_issue      = r_job_valid && (!r_s1_valid || w_s1_adv);

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (w_issue) begin
            r_rd_data <= r_mem[{r_job.bank, r_idx}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
            r_idx       <= '0;
        end else if (i_job_valid) begin
            r_job_valid <= 1'b1;
            r_idx       <= '0;
        end else if (w_issue) begin
            if (w_last_issue) begin
                r_job_valid <= 1'b0;
            end
            r_idx <= r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_job_valid) begin
            r_job <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_issue) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_s1_status <= r_job.status;
            r_s1_addr   <= r_job.addr;
            r_s1_idx    <= w_job_ok ? r_idx : '0;
            r_s1_last   <= w_last_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_out_status <= r_s1_status;
            r_out_addr   <= r_s1_addr;
            r_out_idx    <= r_s1_idx;
            r_out_word   <= (r_s1_status == ufr_pkg::ST_OK) ? r_rd_data : 32'd0;
            r_out_last   <= r_s1_last;
        end
    end

    assign o_job_busy           = r_job_valid;
    assign o_res.valid          = r_out_valid;
    assign o_res.status         = r_out_status;
    assign o_res.device_address = r_out_addr;
    assign o_res.value_index    = ufr_pkg::VALUE_INDEX_W'(r_out_idx);
    assign o_res.value_word     = r_out_word;
    assign o_res.last           = r_out_last;

`ifndef SYNTH
    a_status_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != ufr_pkg::ST_OK) |-> r_out_last)
        else $error("status transaction without last");

    a_job_not_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_job_valid |-> !r_job_valid)
        else $error("new frame verdict while previous one is still being read out");

    a_issue_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_issue |=> r_s1_valid)
        else $error("issued read lost");
`endif

endmodule

`default_nettype wire

// ----- tb/ups_ascii_frame_receiver_top_test.sv -----
`timescale 1ns / 1ps

module ups_ascii_frame_receiver_top_test;

    // Frame layout and the codes a valid analog-data reply must carry.
    localparam int         VALUE_COUNT   = 11;
    localparam int         FRAME_MIN     = 114;
    localparam int         FIRST_VALUE   = 15;
    localparam logic [7:0] FRAME_CMD     = ufr_pkg::CMD_CODE;
    localparam logic [7:0] FRAME_SUB     = ufr_pkg::SUB_CODE;
    localparam logic [7:0] FRAME_RTN_OK  = ufr_pkg::RTN_OK;

    // Run control.
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int HOLD_CYCLES   = 600;
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_LIMIT   = 5000;

    typedef struct packed {
        ufr_pkg::t_status status;
        logic [7:0]       address;
        logic [3:0]       index;
        logic [31:0]      word;
        logic             last;
    } t_reading;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    ufr_byte_if char_ch ();
    ufr_res_if  reading_ch ();

    ups_ascii_frame_receiver_top #(
        .VALUE_COUNT (VALUE_COUNT)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_byte      (char_ch),
        .o_res       (reading_ch)
    );

    // ------------------------------------------------------------------
    // Predictor state. It mirrors the receiver's own registers and is
    // advanced once for every character transaction that the block takes.
    // ------------------------------------------------------------------
    logic [7:0]  open_char;
    logic [7:0]  close_char;
    logic [63:0] accept_map [4];
    logic        frame_open;
    logic [15:0] frame_len_count;
    logic [15:0] body_sum;
    logic [7:0]  recent_chars [4];
    logic [31:0] header_word;
    logic [31:0] value_words [VALUE_COUNT];
    t_reading    due_readings [$];

    // Stimulus and bookkeeping.
    logic [7:0]  char_queue [$];
    int          chars_queued;
    int          chars_accepted;
    int          readings_seen;
    int          frames_passed;
    int          frames_rejected;
    int          mismatches;
    int          cycle_count;
    int          sender_idle_pct;
    int          receiver_idle_pct;
    int          holds_asked;
    int          holds_served;
    int          hold_left;
    logic        char_taken;
    t_reading    head_reading;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Checking helpers.
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("reading %0d, %s: got %0h, expected %0h",
                                      readings_seen, name, got, want));
        end
    endtask

    // ------------------------------------------------------------------
    // Predictor.
    // ------------------------------------------------------------------

    // Anything that is not a hex digit of either case decodes as zero.
    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [7:0] n;
        n = 8'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            n = c - 8'h30;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            n = c - 8'h37;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            n = c - 8'h57;
        end
        return n[3:0];
    endfunction

    function automatic bit is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46)
            || (c >= 8'h61 && c <= 8'h66);
    endfunction

    task automatic queue_reading(input ufr_pkg::t_status st, input logic [7:0] addr,
                                 input logic [3:0] idx, input logic [31:0] word,
                                 input logic last);
        t_reading r;
        r.status  = st;
        r.address = addr;
        r.index   = idx;
        r.word    = word;
        r.last    = last;
        due_readings.push_back(r);
    endtask

    task automatic start_frame();
        frame_open      = 1'b1;
        frame_len_count = 16'd1;
        body_sum        = 16'd0;
        header_word     = 32'd0;
        for (int i = 0; i < 4; i++) begin
            recent_chars[i] = 8'd0;
        end
    endtask

    // Judges a closed frame. The checks run in a fixed order and the first
    // one that fails decides the single status reading.
    task automatic judge_frame();
        int          frame_len;
        logic [7:0]  cmd;
        logic [7:0]  addr;
        logic [7:0]  sub;
        logic [7:0]  rtn;
        logic [15:0] want_sum;
        logic [15:0] got_sum;
        frame_open = 1'b0;
        frame_len  = int'(frame_len_count) + 1;
        cmd        = header_word[31:24];
        addr       = header_word[23:16];
        sub        = header_word[15:8];
        rtn        = header_word[7:0];
        want_sum   = ~body_sum + 16'd1;
        got_sum    = {nibble_of(recent_chars[0]), nibble_of(recent_chars[1]),
                      nibble_of(recent_chars[2]), nibble_of(recent_chars[3])};
        frames_rejected++;
        if (frame_len < FRAME_MIN) begin
            queue_reading(ufr_pkg::ST_SHORT, 8'd0, 4'd0, 32'd0, 1'b1);
        end else if (want_sum != got_sum) begin
            queue_reading(ufr_pkg::ST_CSUM, addr, 4'd0, 32'd0, 1'b1);
        end else if (cmd != FRAME_CMD) begin
            queue_reading(ufr_pkg::ST_CMD, addr, 4'd0, 32'd0, 1'b1);
        end else if (!accept_map[addr[7:6]][addr[5:0]]) begin
            queue_reading(ufr_pkg::ST_ADDR, addr, 4'd0, 32'd0, 1'b1);
        end else if (sub != FRAME_SUB) begin
            queue_reading(ufr_pkg::ST_SUB, addr, 4'd0, 32'd0, 1'b1);
        end else if (rtn != FRAME_RTN_OK) begin
            queue_reading(ufr_pkg::ST_RTN, addr, 4'd0, 32'd0, 1'b1);
        end else begin
            frames_rejected--;
            frames_passed++;
            for (int k = 0; k < VALUE_COUNT; k++) begin
                queue_reading(ufr_pkg::ST_OK, addr, k[3:0], value_words[k],
                              k == VALUE_COUNT - 1);
            end
        end
    endtask

    task automatic predict_char(input logic [7:0] c);
        int pos;
        int slot;
        if (!frame_open) begin
            if (c == open_char) begin
                start_frame();
            end
        end else if (c == close_char) begin
            // The end character wins when both delimiters are the same byte.
            judge_frame();
        end else if (c == open_char) begin
            start_frame();
        end else begin
            pos = int'(frame_len_count);
            // The last four characters are held back as the checksum; a
            // character joins the sum only once it falls out of that window.
            if (pos >= 5) begin
                body_sum = body_sum + recent_chars[0];
            end
            recent_chars[0] = recent_chars[1];
            recent_chars[1] = recent_chars[2];
            recent_chars[2] = recent_chars[3];
            recent_chars[3] = c;
            if (pos >= 1 && pos <= 8) begin
                header_word = {header_word[27:0], nibble_of(c)};
            end
            if (pos >= FIRST_VALUE && pos < FIRST_VALUE + 8 * VALUE_COUNT) begin
                slot = (pos - FIRST_VALUE) / 8;
                value_words[slot] = {value_words[slot][27:0], nibble_of(c)};
            end
            // The length counter sticks at its maximum on very long frames.
            if (frame_len_count != 16'hFFFF) begin
                frame_len_count++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Configuration. Writes are only issued while the block is idle, so
    // the predictor's copy is updated at the same moment.
    // ------------------------------------------------------------------
    task automatic write_reg(input ufr_pkg::t_cfg_index idx, input logic [63:0] value);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            ufr_pkg::CFG_START_CHAR: open_char     = value[7:0];
            ufr_pkg::CFG_END_CHAR:   close_char    = value[7:0];
            ufr_pkg::CFG_IDS_A:      accept_map[0] = value;
            ufr_pkg::CFG_IDS_B:      accept_map[1] = value;
            ufr_pkg::CFG_IDS_C:      accept_map[2] = value;
            ufr_pkg::CFG_IDS_D:      accept_map[3] = value;
            default: ;
        endcase
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_all(input logic [7:0] start_c, input logic [7:0] end_c,
                             input logic [63:0] ids_a, input logic [63:0] ids_b,
                             input logic [63:0] ids_c, input logic [63:0] ids_d);
        write_reg(ufr_pkg::CFG_START_CHAR, {56'd0, start_c});
        write_reg(ufr_pkg::CFG_END_CHAR, {56'd0, end_c});
        write_reg(ufr_pkg::CFG_IDS_A, ids_a);
        write_reg(ufr_pkg::CFG_IDS_B, ids_b);
        write_reg(ufr_pkg::CFG_IDS_C, ids_c);
        write_reg(ufr_pkg::CFG_IDS_D, ids_d);
    endtask

    // ------------------------------------------------------------------
    // Stimulus builders.
    // ------------------------------------------------------------------
    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
        if (n < 4'd10) begin
            return 8'h30 + n;
        end else if (lower) begin
            return 8'h57 + n;
        end
        return 8'h37 + n;
    endfunction

    // Any byte that neither opens nor closes a frame.
    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (c == open_char || c == close_char) begin
            c = 8'($urandom_range(0, 255));
        end
        return c;
    endfunction

    function automatic logic [7:0] random_delimiter();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (is_hex(c)) begin
            c = 8'($urandom_range(0, 255));
        end
        return c;
    endfunction

    function automatic logic [63:0] random_bitmap();
        case ($urandom_range(0, 3))
            0:       return 64'd0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Mostly an address that the current acceptance set lets through.
    function automatic logic [7:0] pick_address(input bit want_known);
        logic [7:0] a;
        a = 8'($urandom_range(0, 255));
        if (want_known) begin
            for (int tries = 0; tries < 64 && !accept_map[a[7:6]][a[5:0]]; tries++) begin
                a = 8'($urandom_range(0, 255));
            end
        end
        return a;
    endfunction

    task automatic send_char(input logic [7:0] c);
        char_queue.push_back(c);
        chars_queued++;
    endtask

    // A complete reply frame: header, a length area of plain bytes, eleven
    // eight-character values, padding, checksum and end character. body_len
    // counts the characters between the two delimiters and must be 107 or more.
    task automatic send_frame(input logic [7:0] cmd, input logic [7:0] addr,
                              input logic [7:0] sub, input logic [7:0] rtn,
                              input int body_len, input logic [15:0] csum_skew,
                              input bit lower, input bit garble);
        logic [31:0] head;
        logic [31:0] w;
        logic [15:0] sum;
        logic [15:0] csum;
        logic [7:0]  c;
        head = {cmd, addr, sub, rtn};
        sum  = 16'd0;
        w    = 32'd0;
        send_char(open_char);
        for (int pos = 1; pos <= body_len - 4; pos++) begin
            if (pos <= 8) begin
                c = hex_char(head[31 - 4 * (pos - 1) -: 4], lower);
            end else if (pos >= FIRST_VALUE && pos < FIRST_VALUE + 8 * VALUE_COUNT) begin
                if ((pos - FIRST_VALUE) % 8 == 0) begin
                    w = $urandom;
                end
                c = hex_char(w[31:28], lower);
                w = w << 4;
                if (garble && $urandom_range(0, 3) == 0) begin
                    c = plain_char();
                end
            end else begin
                c = plain_char();
            end
            sum = sum + c;
            send_char(c);
        end
        csum = ~sum + 16'd1 + csum_skew;
        for (int i = 0; i < 4; i++) begin
            send_char(hex_char(csum[15 - 4 * i -: 4], lower));
        end
        send_char(close_char);
    endtask

    task automatic send_short(input int n);
        send_char(open_char);
        repeat (n) send_char(plain_char());
        send_char(close_char);
    endtask

    // One random sequence. Most are well-formed frames with random content
    // and an occasional fault; the rest are short frames and raw noise.
    task automatic send_random_sequence();
        int          kind;
        logic [7:0]  cmd;
        logic [7:0]  sub;
        logic [7:0]  rtn;
        logic [15:0] skew;
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
            cmd  = ($urandom_range(0, 9) == 0) ? 8'($urandom) : FRAME_CMD;
            sub  = ($urandom_range(0, 9) == 0) ? 8'($urandom) : FRAME_SUB;
            rtn  = ($urandom_range(0, 9) == 0) ? 8'($urandom) : FRAME_RTN_OK;
            skew = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(1, 65535)) : 16'd0;
            send_frame(cmd, pick_address($urandom_range(0, 4) != 0), sub, rtn,
                       ($urandom_range(0, 9) == 0) ? $urandom_range(107, 111)
                                                   : $urandom_range(112, 120),
                       skew, 1'($urandom_range(0, 1)), $urandom_range(0, 4) == 0);
        end else if (kind < 85) begin
            send_short($urandom_range(0, 20));
        end else begin
            repeat ($urandom_range(1, 8)) send_char(8'($urandom_range(0, 255)));
        end
    endtask

    // Waits until every queued character has been taken and every expected
    // reading has arrived, then lets the block settle. Readings that never
    // came are failures; they are dropped so that the run can go on.
    task automatic drain();
        int waited;
        while (chars_accepted != chars_queued) @(negedge i_clk);
        waited = 0;
        while (due_readings.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (due_readings.size() != 0) begin
            report_mismatch($sformatf("%0d expected readings never arrived",
                                      due_readings.size()));
            due_readings.delete();
        end
    endtask

    // ------------------------------------------------------------------
    // Character driver. A new transaction is offered at the falling edge
    // once the previous one has been taken, with random gaps.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        char_taken = 1'b0;
        if (i_rst_n && char_ch.valid && char_ch.ready) begin
            char_taken = 1'b1;
            chars_accepted++;
            predict_char(char_ch.in_byte);
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            char_ch.valid <= 1'b0;
        end else if (!char_ch.valid || char_taken) begin
            if (char_queue.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                char_ch.in_byte <= char_queue.pop_front();
                char_ch.valid   <= 1'b1;
            end else begin
                char_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Reading sink. Ready is dropped at random; when asked, it is held low
    // for a long stretch so that the block's buffers fill and it stalls
    // its character input.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left--;
            reading_ch.ready <= 1'b0;
        end else if (holds_served != holds_asked) begin
            holds_served++;
            hold_left = HOLD_CYCLES - 1;
            reading_ch.ready <= 1'b0;
        end else begin
            reading_ch.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    // Every reading transaction is compared, field by field, with the
    // oldest outstanding prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && reading_ch.valid && reading_ch.ready) begin
            readings_seen++;
            if (due_readings.size() == 0) begin
                report_mismatch($sformatf("unexpected reading: status %0d address %02h",
                                          reading_ch.status, reading_ch.device_address));
            end else begin
                head_reading = due_readings.pop_front();
                check_field("status", reading_ch.status, head_reading.status);
                check_field("device_address", reading_ch.device_address,
                            head_reading.address);
                check_field("value_index", reading_ch.value_index, head_reading.index);
                check_field("value_word", reading_ch.value_word, head_reading.word);
                check_field("last", reading_ch.last, head_reading.last);
            end
        end
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d readings outstanding",
                     cycle_count, due_readings.size());
            $display("ups_ascii_frame_receiver_top_test NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------
    initial begin
        int batch;
        int rand_first_char;
        int rand_first_reading;

        // Inputs and predictor start from the reset state.
        i_rst_n          = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = 3'd0;
        cfg_data         = 64'd0;
        char_ch.valid    = 1'b0;
        char_ch.in_byte  = 8'd0;
        reading_ch.ready = 1'b0;
        open_char        = 8'h7E;
        close_char       = 8'h0D;
        frame_open       = 1'b0;
        frame_len_count  = 16'd0;
        body_sum         = 16'd0;
        header_word      = 32'd0;
        char_taken       = 1'b0;
        for (int i = 0; i < 4; i++) begin
            accept_map[i]   = 64'd0;
            recent_chars[i] = 8'd0;
        end
        for (int k = 0; k < VALUE_COUNT; k++) begin
            value_words[k] = 32'd0;
        end
        chars_queued      = 0;
        chars_accepted    = 0;
        readings_seen     = 0;
        frames_passed     = 0;
        frames_rejected   = 0;
        mismatches        = 0;
        cycle_count       = 0;
        holds_asked       = 0;
        holds_served      = 0;
        hold_left         = 0;
        // First idling pattern: a mostly busy sender and a reluctant sink.
        sender_idle_pct   = 24;
        receiver_idle_pct = 58;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Default configuration. Characters outside a frame, the end
        // character among them, are ignored. An empty frame and a tiny one
        // are short, and a full frame is refused since no address is accepted.
        send_char(8'h0D);
        send_char(8'h00);
        send_char(8'hFF);
        send_char(8'h41);
        send_short(0);
        send_short(3);
        send_frame(FRAME_CMD, 8'h01, FRAME_SUB, FRAME_RTN_OK, 112, 16'd0, 1'b0, 1'b0);
        drain();

        // An acceptance set with a different pattern in each bank, so that
        // neighbouring addresses fall on either side of the check.
        write_all(8'h7E, 8'h0D, '1, {32{2'b01}}, {32{2'b10}}, 64'h8000_0000_0000_0001);
        // The shortest frame that may pass, then one character shorter.
        send_frame(FRAME_CMD, 8'h00, FRAME_SUB, FRAME_RTN_OK, 112, 16'd0, 1'b0, 1'b0);
        send_frame(FRAME_CMD, 8'h40, FRAME_SUB, FRAME_RTN_OK, 111, 16'd0, 1'b0, 1'b0);
        // One fault per check, each in an otherwise sound frame.
        send_frame(FRAME_CMD, 8'h81, FRAME_SUB, FRAME_RTN_OK, 112, 16'd1, 1'b0, 1'b0);
        send_frame(8'h12, 8'h3F, FRAME_SUB, FRAME_RTN_OK, 113, 16'd0, 1'b0, 1'b0);
        send_frame(FRAME_CMD, 8'h41, FRAME_SUB, FRAME_RTN_OK, 112, 16'd0, 1'b0, 1'b0);
        send_frame(FRAME_CMD, 8'hFF, 8'h2B, FRAME_RTN_OK, 112, 16'd0, 1'b0, 1'b0);
        send_frame(FRAME_CMD, 8'hC0, FRAME_SUB, 8'h01, 112, 16'd0, 1'b0, 1'b0);
        // Lower-case hex with some value characters replaced by random non-delimiter bytes.
        send_frame(FRAME_CMD, 8'h3F, FRAME_SUB, FRAME_RTN_OK, 120, 16'd0, 1'b1, 1'b1);
        // A start character inside an open frame restarts it silently.
        send_char(open_char);
        repeat (30) send_char(plain_char());
        send_frame(FRAME_CMD, 8'hFF, FRAME_SUB, FRAME_RTN_OK, 112, 16'd0, 1'b0, 1'b0);
        drain();

        // Back-pressure: the sink holds off while three good frames arrive.
        holds_asked++;
        repeat (3) begin
            send_frame(FRAME_CMD, pick_address(1'b1), FRAME_SUB, FRAME_RTN_OK,
                       $urandom_range(112, 120), 16'd0, 1'($urandom_range(0, 1)), 1'b0);
        end
        drain();

        // Extreme delimiters with every address accepted; the old delimiters
        // are now ordinary content.
        write_all(8'h00, 8'hFF, '1, '1, '1, '1);
        send_frame(FRAME_CMD, 8'h9C, FRAME_SUB, FRAME_RTN_OK, 116, 16'd0, 1'b0, 1'b0);
        send_short(5);
        drain();

        // The same byte opens and closes a frame.
        write_all(8'hFF, 8'hFF, 64'd0, 64'd0, 64'd0, '1);
        send_frame(FRAME_CMD, 8'hD5, FRAME_SUB, FRAME_RTN_OK, 112, 16'd0, 1'b0, 1'b0);
        send_frame(FRAME_CMD, 8'h15, FRAME_SUB, FRAME_RTN_OK, 112, 16'd0, 1'b0, 1'b0);
        send_short(2);
        drain();

        // Random part, in batches with an occasional new configuration
        // between them. The idling pattern is reversed first and then
        // switched off.
        rand_first_char    = chars_queued;
        rand_first_reading = readings_seen;
        batch              = 0;
        while (batch < 6 || chars_queued - rand_first_char < 370
               || readings_seen - rand_first_reading < 48) begin
            if (batch == 0) begin
                sender_idle_pct   = 58;
                receiver_idle_pct = 24;
            end else if (batch == 3) begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            if ($urandom_range(0, 1) == 0) begin
                write_all(random_delimiter(),
                          ($urandom_range(0, 6) == 0) ? open_char : random_delimiter(),
                          random_bitmap(), random_bitmap(), random_bitmap(),
                          random_bitmap());
            end
            repeat ($urandom_range(1, 2)) send_random_sequence();
            drain();
            batch++;
        end

        $display("Run covered %0d characters, %0d frames passed and %0d refused,",
                 chars_accepted, frames_passed, frames_rejected);
        $display("with %0d readings checked under %0d random batches; %0d mismatches.",
                 readings_seen, batch, mismatches);
        if (mismatches == 0) begin
            $display("ups_ascii_frame_receiver_top_test OK");
        end else begin
            $display("ups_ascii_frame_receiver_top_test NOT OK");
        end
        $finish;
    end

endmodule
